@@ design/ies_pkg.sv @@
// Package for the isotropic elastic stress block: widths, register indexes,
// reset configuration and the beat and coefficient struct types.
// No dependencies.
package ies_pkg;

    localparam int STRAIN_W    = 32;
    localparam int STRESS_W    = 64;
    localparam int COEF_W      = 56;
    localparam int YOUNG_W     = 32;
    localparam int POISSON_W   = 15;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_YOUNG_MODULUS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POISSON_RATIO = 1'd1;

    localparam logic [YOUNG_W-1:0]   YOUNG_RESET   = 32'd210000;
    localparam logic [POISSON_W-1:0] POISSON_RESET = 15'd19661;

    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

    typedef struct packed {
        logic signed [STRAIN_W-1:0] strain_xx;
        logic signed [STRAIN_W-1:0] strain_yy;
        logic signed [STRAIN_W-1:0] strain_zz;
        logic signed [STRAIN_W-1:0] strain_xy;
        logic signed [STRAIN_W-1:0] strain_yz;
        logic signed [STRAIN_W-1:0] strain_xz;
    } strain_t;

    typedef struct packed {
        logic signed [STRESS_W-1:0] stress_xx;
        logic signed [STRESS_W-1:0] stress_yy;
        logic signed [STRESS_W-1:0] stress_zz;
        logic signed [STRESS_W-1:0] stress_xy;
        logic signed [STRESS_W-1:0] stress_yz;
        logic signed [STRESS_W-1:0] stress_xz;
        logic [COEF_W-1:0]          coef_normal_diag;
        logic [COEF_W-1:0]          coef_normal_off;
        logic [COEF_W-1:0]          coef_shear;
    } result_t;

    typedef struct packed {
        logic [COEF_W-1:0] diag;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] shear;
    } coef_t;

endpackage

@@ design/ies_coef_unit.sv @@
// Configuration registers and stiffness coefficient derivation for the
// isotropic elastic stress block: a shared restoring divider, one bit a cycle.
// Depends on ies_pkg.
module ies_coef_unit
    import ies_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   busy,
    output coef_t                  coef
);

    localparam int DIV_W  = 72;
    localparam int DEN_W  = 33;
    localparam int REM_W  = DEN_W + 1;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int FRAC_A = 24;
    localparam int FRAC_G = 23;

    localparam logic [1:0] TERM_DIAG  = 2'd0;
    localparam logic [1:0] TERM_OFF   = 2'd1;
    localparam logic [1:0] TERM_SHEAR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_LOAD  = 4'b0100,
        ST_DIV   = 4'b1000
    } deriv_state_t;

    deriv_state_t           state_reg, state_next;
    logic [1:0]             term_reg, term_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [YOUNG_W-1:0]     young_reg, young_next;
    logic [POISSON_W-1:0]   poisson_reg, poisson_next;

    logic [47:0]            prod_diag_reg, prod_diag_next;
    logic [46:0]            prod_off_reg, prod_off_next;
    logic [DEN_W-1:0]       den_reg, den_next;
    logic [16:0]            gsh_reg, gsh_next;
    logic [DIV_W-1:0]       num_reg, num_next;
    logic [DIV_W-1:0]       quot_reg, quot_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [DEN_W-1:0]       divisor_reg, divisor_next;
    coef_t                  coef_reg, coef_next;

    logic [16:0]            nu17;
    logic [16:0]            one_minus_nu;
    logic [16:0]            one_minus_2nu;
    logic [48:0]            diag_prod;
    logic [46:0]            off_prod;
    logic [33:0]            den_full;
    logic [REM_W-1:0]       trial;
    logic                   qbit;
    logic [DIV_W-1:0]       quot_final;
    logic [COEF_W-1:0]      coef_sat;

    assign nu17          = {2'b00, poisson_reg};
    assign gsh_next      = 17'h10000 + nu17;
    assign one_minus_nu  = 17'h10000 - nu17;
    assign one_minus_2nu = 17'h10000 - {1'b0, poisson_reg, 1'b0};
    assign diag_prod     = young_reg * one_minus_nu;
    assign off_prod      = young_reg * poisson_reg;
    assign den_full      = gsh_next * one_minus_2nu;

    assign trial      = {rem_reg[REM_W-2:0], num_reg[DIV_W-1]};
    assign qbit       = (trial >= {1'b0, divisor_reg});
    assign quot_final = {quot_reg[DIV_W-2:0], qbit};
    assign coef_sat   = (|quot_final[DIV_W-1:COEF_W]) ? COEF_MAX : quot_final[COEF_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        term_next      = term_reg;
        count_next     = count_reg;
        young_next     = young_reg;
        poisson_next   = poisson_reg;
        prod_diag_next = prod_diag_reg;
        prod_off_next  = prod_off_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        coef_next      = coef_reg;

        case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SETUP:
            begin
                prod_diag_next = diag_prod[47:0];
                prod_off_next  = off_prod;
                den_next       = den_full[DEN_W-1:0];
                term_next      = TERM_DIAG;
                state_next     = ST_LOAD;
            end
            ST_LOAD:
            begin
                rem_next   = '0;
                quot_next  = '0;
                count_next = CNT_W'(DIV_W);
                case (term_reg)
                    TERM_DIAG:
                    begin
                        num_next     = {prod_diag_reg, {FRAC_A{1'b0}}}
                                     + {40'b0, den_reg[DEN_W-1:1]};
                        divisor_next = den_reg;
                    end
                    TERM_OFF:
                    begin
                        num_next     = {1'b0, prod_off_reg, {FRAC_A{1'b0}}}
                                     + {40'b0, den_reg[DEN_W-1:1]};
                        divisor_next = den_reg;
                    end
                    default:
                    begin
                        num_next     = {17'b0, young_reg, {FRAC_G{1'b0}}}
                                     + {56'b0, gsh_reg[16:1]};
                        divisor_next = {16'b0, gsh_reg};
                    end
                endcase
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next   = qbit ? (trial - {1'b0, divisor_reg}) : trial;
                num_next   = {num_reg[DIV_W-2:0], 1'b0};
                quot_next  = quot_final;
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    case (term_reg)
                        TERM_DIAG:
                        begin
                            coef_next.diag = coef_sat;
                            term_next      = TERM_OFF;
                            state_next     = ST_LOAD;
                        end
                        TERM_OFF:
                        begin
                            coef_next.off = coef_sat;
                            term_next     = TERM_SHEAR;
                            state_next    = ST_LOAD;
                        end
                        default:
                        begin
                            coef_next.shear = coef_sat;
                            state_next      = ST_IDLE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_SETUP;
            end
        endcase

        // restart the derivation on any register write
        if (cfg_write)
        begin
            case (cfg_index)
                REG_YOUNG_MODULUS:
                begin
                    young_next = cfg_data[YOUNG_W-1:0];
                    state_next = ST_SETUP;
                end
                REG_POISSON_RATIO:
                begin
                    poisson_next = cfg_data[POISSON_W-1:0];
                    state_next   = ST_SETUP;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_SETUP;
            term_reg    <= TERM_DIAG;
            count_reg   <= '0;
            young_reg   <= YOUNG_RESET;
            poisson_reg <= POISSON_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            term_reg    <= term_next;
            count_reg   <= count_next;
            young_reg   <= young_next;
            poisson_reg <= poisson_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_diag_reg <= prod_diag_next;
        prod_off_reg  <= prod_off_next;
        den_reg       <= den_next;
        gsh_reg       <= gsh_next;
        num_reg       <= num_next;
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        divisor_reg   <= divisor_next;
        coef_reg      <= coef_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign coef = coef_reg;

endmodule

@@ design/ies_stress_pipe.sv @@
// Stress datapath of the isotropic elastic stress block: input register,
// split partial products, partial sums with rounding, result register.
// Depends on ies_pkg.
module ies_stress_pipe
    import ies_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  strain_t strain,
    input  coef_t   coef,
    output logic    done,
    output result_t result
);

    localparam int LANES  = 6;
    localparam int OPND_W = STRAIN_W + 1;
    localparam int HALF_W = COEF_W / 2;
    localparam int PROD_W = HALF_W + 1 + OPND_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SHIFT  = 29;
    localparam int TOT_W  = STRESS_W + SHIFT;

    strain_t                   strain_reg;
    logic                      v0_reg, v1_reg, v2_reg, v3_reg;
    result_t                   result_reg, result_next;

    logic signed [OPND_W-1:0]  e [LANES];
    logic signed [OPND_W-1:0]  x1 [LANES];
    logic signed [OPND_W-1:0]  x2 [LANES];
    logic [COEF_W-1:0]         c1 [LANES];
    logic [COEF_W-1:0]         c2 [LANES];
    logic [STRESS_W-1:0]       lane_stress [LANES];

    always_comb
    begin
        e[0] = $signed({strain_reg.strain_xx[STRAIN_W-1], strain_reg.strain_xx});
        e[1] = $signed({strain_reg.strain_yy[STRAIN_W-1], strain_reg.strain_yy});
        e[2] = $signed({strain_reg.strain_zz[STRAIN_W-1], strain_reg.strain_zz});
        e[3] = $signed({strain_reg.strain_xy[STRAIN_W-1], strain_reg.strain_xy});
        e[4] = $signed({strain_reg.strain_yz[STRAIN_W-1], strain_reg.strain_yz});
        e[5] = $signed({strain_reg.strain_xz[STRAIN_W-1], strain_reg.strain_xz});

        c1[0] = coef.diag;  x1[0] = e[0];  c2[0] = coef.off;  x2[0] = e[1] + e[2];
        c1[1] = coef.diag;  x1[1] = e[1];  c2[1] = coef.off;  x2[1] = e[2] + e[0];
        c1[2] = coef.diag;  x1[2] = e[2];  c2[2] = coef.off;  x2[2] = e[0] + e[1];
        c1[3] = coef.shear; x1[3] = e[3];  c2[3] = '0;        x2[3] = '0;
        c1[4] = coef.shear; x1[4] = e[4];  c2[4] = '0;        x2[4] = '0;
        c1[5] = coef.shear; x1[5] = e[5];  c2[5] = '0;        x2[5] = '0;
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [PROD_W-1:0] hi1_next, lo1_next, hi2_next, lo2_next;
        logic signed [PROD_W-1:0] hi1_reg, lo1_reg, hi2_reg, lo2_reg;
        logic signed [SUM_W-1:0]  hi_sum_reg, lo_sum_reg;
        logic signed [SUM_W-1:0]  hi_sum_next, lo_sum_next;
        logic signed [TOT_W-1:0]  total;

        assign hi1_next = $signed({1'b0, c1[l][COEF_W-1:HALF_W]}) * x1[l];
        assign lo1_next = $signed({1'b0, c1[l][HALF_W-1:0]}) * x1[l];
        assign hi2_next = $signed({1'b0, c2[l][COEF_W-1:HALF_W]}) * x2[l];
        assign lo2_next = $signed({1'b0, c2[l][HALF_W-1:0]}) * x2[l];

        assign hi_sum_next = $signed({hi1_reg[PROD_W-1], hi1_reg})
                           + $signed({hi2_reg[PROD_W-1], hi2_reg});
        assign lo_sum_next = $signed({lo1_reg[PROD_W-1], lo1_reg})
                           + $signed({lo2_reg[PROD_W-1], lo2_reg})
                           + $signed(SUM_W'(1) << (SHIFT - 1));

        assign total = $signed({{(TOT_W - SUM_W - HALF_W){hi_sum_reg[SUM_W-1]}},
                                hi_sum_reg, {HALF_W{1'b0}}})
                     + $signed({{(TOT_W - SUM_W){lo_sum_reg[SUM_W-1]}}, lo_sum_reg});

        assign lane_stress[l] = total[TOT_W-1:SHIFT];

        always_ff @(posedge clk)
        begin
            hi1_reg    <= hi1_next;
            lo1_reg    <= lo1_next;
            hi2_reg    <= hi2_next;
            lo2_reg    <= lo2_next;
            hi_sum_reg <= hi_sum_next;
            lo_sum_reg <= lo_sum_next;
        end
    end

    always_comb
    begin
        result_next.stress_xx        = lane_stress[0];
        result_next.stress_yy        = lane_stress[1];
        result_next.stress_zz        = lane_stress[2];
        result_next.stress_xy        = lane_stress[3];
        result_next.stress_yz        = lane_stress[4];
        result_next.stress_xz        = lane_stress[5];
        result_next.coef_normal_diag = coef.diag;
        result_next.coef_normal_off  = coef.off;
        result_next.coef_shear       = coef.shear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            strain_reg <= strain;
        end
        if (v2_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = v3_reg;
    assign result = result_reg;

endmodule

@@ design/isotropic_elastic_stress_top.sv @@
// Isotropic linear elastic stress, top level. Depends on ies_pkg,
// ies_coef_unit and ies_stress_pipe.
// Throughput: one strain beat per clock while busy is low.
// Beats pass input, product, sum and result registers; done is high one cycle per beat.
// Reset and every register write run the coefficient derivation (shared
// 72-step divider, three terms) while busy stays high; done never waits.
module isotropic_elastic_stress_top
    import ies_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  strain_t                strain,
    output logic                   busy,
    output logic                   done,
    output result_t                result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    coef_t coef;
    logic  accept;

    assign accept = start & ~busy;

    ies_coef_unit u_coef
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .coef      (coef)
    );

    ies_stress_pipe u_pipe
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .strain (strain),
        .coef   (coef),
        .done   (done),
        .result (result)
    );

endmodule

@@ tb/tb.sv @@
// Self-checking bench for isotropic_elastic_stress_top: strain beats in, stress and
// stiffness terms out, scored against an in-bench Hooke's law model across configurations.
// Depends on ies_pkg and the block's RTL.
module tb
    import ies_pkg::*;
();

    localparam int ITEMS      = 1550;
    localparam int SETTINGS_N = 10;
    localparam int LIMIT      = 120000;

    class hooke_scoreboard;
        logic [YOUNG_W-1:0]   young;
        logic [POISSON_W-1:0] poisson;
        coef_t                terms;
        result_t              expected_stress[$];
        int                   mismatches;

        function new();
            young      = YOUNG_RESET;
            poisson    = POISSON_RESET;
            mismatches = 0;
            derive_terms();
        endfunction

        function logic [COEF_W-1:0] round_div(logic [127:0] num, logic [127:0] den);
            logic [127:0] q;
            q = (num + den / 2) / den;
            return (q > COEF_MAX) ? COEF_MAX : q[COEF_W-1:0];
        endfunction

        function void derive_terms();
            logic [127:0] e, n, g, d;
            e = young;
            n = poisson;
            g = 128'd65536 + n;
            d = g * (128'd65536 - 2 * n);
            terms.diag  = round_div((e * (128'd65536 - n)) << 24, d);
            terms.off   = round_div((e * n) << 24, d);
            terms.shear = round_div(e << 23, g);
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_YOUNG_MODULUS)
                young = data[YOUNG_W-1:0];
            else if (idx == REG_POISSON_RATIO)
                poisson = data[POISSON_W-1:0];
            derive_terms();
        endfunction

        function logic signed [127:0] product(logic [COEF_W-1:0] c, logic signed [31:0] s);
            logic signed [127:0] cw, sw;
            cw = {72'd0, c};
            sw = s;
            return cw * sw;
        endfunction

        function logic signed [STRESS_W-1:0] round_stress(logic signed [127:0] acc);
            logic signed [127:0] r;
            r = (acc + 128'sd268435456) >>> 29;
            if (r[127:63] != {65{r[127]}})
                return r[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            return r[63:0];
        endfunction

        function void note_strain(strain_t s);
            result_t r;
            r.stress_xx = round_stress(product(terms.diag, s.strain_xx)
                + product(terms.off, s.strain_yy) + product(terms.off, s.strain_zz));
            r.stress_yy = round_stress(product(terms.diag, s.strain_yy)
                + product(terms.off, s.strain_zz) + product(terms.off, s.strain_xx));
            r.stress_zz = round_stress(product(terms.diag, s.strain_zz)
                + product(terms.off, s.strain_xx) + product(terms.off, s.strain_yy));
            r.stress_xy = round_stress(product(terms.shear, s.strain_xy));
            r.stress_yz = round_stress(product(terms.shear, s.strain_yz));
            r.stress_xz = round_stress(product(terms.shear, s.strain_xz));
            r.coef_normal_diag = terms.diag;
            r.coef_normal_off  = terms.off;
            r.coef_shear       = terms.shear;
            expected_stress.insert(expected_stress.size(), r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
            if (seen !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%s mismatch: expected %h, got %h", name, want, seen);
            end
        endfunction

        function void check_stress(result_t got);
            result_t exp;
            if (expected_stress.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %h", got);
                return;
            end
            exp = expected_stress.pop_front();
            compare_field("stress_xx", exp.stress_xx, got.stress_xx);
            compare_field("stress_yy", exp.stress_yy, got.stress_yy);
            compare_field("stress_zz", exp.stress_zz, got.stress_zz);
            compare_field("stress_xy", exp.stress_xy, got.stress_xy);
            compare_field("stress_yz", exp.stress_yz, got.stress_yz);
            compare_field("stress_xz", exp.stress_xz, got.stress_xz);
            compare_field("coef_normal_diag", exp.coef_normal_diag, got.coef_normal_diag);
            compare_field("coef_normal_off", exp.coef_normal_off, got.coef_normal_off);
            compare_field("coef_shear", exp.coef_shear, got.coef_shear);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    strain_t                strain;
    logic                   busy;
    logic                   done;
    result_t                result;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    hooke_scoreboard hooke;
    int              cycles;
    int              sent;
    int              calm;
    logic [YOUNG_W-1:0]    young_set[SETTINGS_N];
    logic [CFG_DATA_W-1:0] poisson_set[SETTINGS_N];

    isotropic_elastic_stress_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .strain    (strain),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            hooke.check_stress(result);
    end

    function automatic logic [31:0] strain_value();
        logic [31:0] r;
        int          sel;
        r   = $urandom;
        sel = $urandom_range(9);
        if (sel < 6)
            return r;
        if (sel < 8)
            return {{12{r[20]}}, r[19:0]};
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic strain_t random_strain();
        return {strain_value(), strain_value(), strain_value(),
                strain_value(), strain_value(), strain_value()};
    endfunction

    task automatic send_strain(input strain_t s);
        int pct;
        @(negedge clk);
        start  <= 1'b1;
        strain <= s;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        hooke.note_strain(s);
        sent++;
        pct = (sent < ITEMS / 3) ? 25 : (sent < 2 * ITEMS / 3) ? 83 : 0;
        if (calm > 0)
            calm--;
        else if ($urandom_range(19) == 0)
            calm = $urandom_range(10, 30);
        if (calm == 0)
        begin
            while ($urandom_range(99) < pct)
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (hooke.expected_stress.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        hooke.set_register(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        do
            @(posedge clk);
        while (busy !== 1'b1);
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic run_directed();
        strain_t s;
        send_strain('0);
        send_strain({6{32'h7FFF_FFFF}});
        send_strain({6{32'h8000_0000}});
        send_strain({6{32'hFFFF_FFFF}});
        send_strain({6{32'h0000_0001}});
        send_strain({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}});
        send_strain({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}});
        send_strain({3{32'h5555_5555, 32'hAAAA_AAAA}});
        send_strain({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        for (int i = 0; i < 6; i++)
        begin
            s = '0;
            s[191-32*i -: 32] = 32'h2000_0000;
            send_strain(s);
        end
    endtask

    initial
    begin
        int fails;
        int per_phase;
        hooke     = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        strain    = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        cycles    = 0;
        sent      = 0;
        calm      = 0;
        per_phase = ITEMS / SETTINGS_N;

        young_set[0] = YOUNG_RESET;    poisson_set[0] = POISSON_RESET;
        young_set[1] = 32'd1;          poisson_set[1] = 32'd0;
        young_set[2] = 32'hFFFF_FFFF;  poisson_set[2] = 32'd32767;
        young_set[3] = 32'd0;          poisson_set[3] = 32'd19661;
        young_set[4] = 32'hFFFF_FFFF;  poisson_set[4] = 32'd0;
        young_set[5] = 32'd1;          poisson_set[5] = 32'hFFFF_FFFF;
        for (int k = 6; k < SETTINGS_N; k++)
        begin
            young_set[k]   = (k % 2) ? $urandom : $urandom_range(1, 1000000);
            poisson_set[k] = $urandom;
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < SETTINGS_N; k++)
        begin
            if (k > 0)
            begin
                drain();
                if (k % 2)
                begin
                    write_reg(REG_YOUNG_MODULUS, young_set[k]);
                    write_reg(REG_POISSON_RATIO, poisson_set[k]);
                end
                else
                begin
                    write_reg(REG_POISSON_RATIO, poisson_set[k]);
                    write_reg(REG_YOUNG_MODULUS, young_set[k]);
                end
            end
            else
                run_directed();
            while (sent < per_phase * (k + 1))
                send_strain(random_strain());
        end

        drain();
        fails = hooke.mismatches + hooke.expected_stress.size();
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
